// ----- design/thumb_data_processing_unit_macros.svh -----
// Assertion macros for the Thumb data-processing unit.
// Included by the modules that carry assertions; expects clk and rst_n in scope.
`ifndef THUMB_DATA_PROCESSING_UNIT_MACROS_SVH
`define THUMB_DATA_PROCESSING_UNIT_MACROS_SVH

// same-cycle implication
`define TDPU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TDPU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tdpu_pkg.sv -----
// Types and constants shared by the Thumb data-processing unit.
// No dependencies.
package tdpu_pkg;

  localparam int REG_COUNT = 8;
  localparam int REG_AW    = $clog2(REG_COUNT);

  localparam logic [1:0] STATUS_EXEC    = 2'd0;
  localparam logic [1:0] STATUS_UNSUP   = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  localparam logic [1:0] IMM_MOV = 2'd0;
  localparam logic [1:0] IMM_CMP = 2'd1;
  localparam logic [1:0] IMM_ADD = 2'd2;
  localparam logic [1:0] IMM_SUB = 2'd3;

  typedef enum logic [2:0] {
    KIND_ALU     = 3'd0,
    KIND_ADDSUB  = 3'd1,
    KIND_SHIFT   = 3'd2,
    KIND_IMM8    = 3'd3,
    KIND_UNSUP   = 3'd4,
    KIND_UNKNOWN = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    ALU_AND = 4'd0,
    ALU_EOR = 4'd1,
    ALU_LSL = 4'd2,
    ALU_LSR = 4'd3,
    ALU_ASR = 4'd4,
    ALU_ADC = 4'd5,
    ALU_SBC = 4'd6,
    ALU_ROR = 4'd7,
    ALU_TST = 4'd8,
    ALU_NEG = 4'd9,
    ALU_CMP = 4'd10,
    ALU_CMN = 4'd11,
    ALU_ORR = 4'd12,
    ALU_MUL = 4'd13,
    ALU_BIC = 4'd14,
    ALU_MVN = 4'd15
  } alu_op_t;

  typedef struct packed {
    kind_t             kind;
    logic [REG_AW-1:0] rd;
    logic [REG_AW-1:0] addr_a;
    logic [REG_AW-1:0] addr_b;
  } dec_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              we;
    logic [REG_AW-1:0] rd;
    logic [31:0]       value;
    logic [3:0]        flags;
  } exe_t;

endpackage

// ----- design/tdpu_decode.sv -----
// Format classification and operand addressing for one Thumb word.
// Depends on tdpu_pkg.
module tdpu_decode (
  input  logic [15:0]    instruction,
  output tdpu_pkg::dec_t dec
);

  tdpu_pkg::kind_t kind;

  always_comb begin
    if (instruction[15:8] inside {8'hDF, 8'hB0}) begin
      kind = tdpu_pkg::KIND_UNSUP;
    end else if (instruction[15:10] == 6'h11) begin
      kind = tdpu_pkg::KIND_UNSUP;
    end else if (instruction[15:10] == 6'h10) begin
      kind = tdpu_pkg::KIND_ALU;
    end else if (instruction[15:11] == 5'h03) begin
      kind = tdpu_pkg::KIND_ADDSUB;
    end else if (instruction[15:11] inside {5'h09, 5'h1C}) begin
      kind = tdpu_pkg::KIND_UNSUP;
    end else if (instruction[15:12] inside {4'h5, 4'h8, 4'h9, 4'hA, 4'hC, 4'hD, 4'hF}) begin
      kind = tdpu_pkg::KIND_UNSUP;
    end else if (instruction[15:12] == 4'hB && instruction[10:9] == 2'b10) begin
      kind = tdpu_pkg::KIND_UNSUP;
    end else if (instruction[15:13] == 3'd0) begin
      kind = tdpu_pkg::KIND_SHIFT;
    end else if (instruction[15:13] == 3'd1) begin
      kind = tdpu_pkg::KIND_IMM8;
    end else if (instruction[15:13] == 3'd3) begin
      kind = tdpu_pkg::KIND_UNSUP;
    end else begin
      kind = tdpu_pkg::KIND_UNKNOWN;
    end
  end

  always_comb begin
    dec.kind   = kind;
    dec.rd     = instruction[2:0];
    dec.addr_a = instruction[5:3];
    dec.addr_b = instruction[5:3];
    case (kind)
      tdpu_pkg::KIND_IMM8: begin
        dec.rd     = instruction[10:8];
        dec.addr_a = instruction[10:8];
      end
      tdpu_pkg::KIND_ALU: begin
        dec.addr_a = instruction[2:0];
      end
      tdpu_pkg::KIND_ADDSUB: begin
        dec.addr_b = instruction[8:6];
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- design/tdpu_regfile.sv -----
// Eight 32-bit low registers: array with registered reads, write bypass and
// per-entry valid bits so that unwritten entries read as zero. Depends on tdpu_pkg.
module tdpu_regfile (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [tdpu_pkg::REG_AW-1:0] rd_addr_a,
  input  logic [tdpu_pkg::REG_AW-1:0] rd_addr_b,
  output logic [31:0]                 rd_data_a,
  output logic [31:0]                 rd_data_b,
  input  logic                        wr_en,
  input  logic [tdpu_pkg::REG_AW-1:0] wr_addr,
  input  logic [31:0]                 wr_data
);

  logic [31:0]                    mem [tdpu_pkg::REG_COUNT];
  logic [tdpu_pkg::REG_COUNT-1:0] valid_r;
  logic [31:0]                    rd_data_a_r;
  logic [31:0]                    rd_data_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && wr_addr == rd_addr_a) begin
        rd_data_a_r <= wr_data;
      end else if (valid_r[rd_addr_a]) begin
        rd_data_a_r <= mem[rd_addr_a];
      end else begin
        rd_data_a_r <= '0;
      end
      if (wr_en && wr_addr == rd_addr_b) begin
        rd_data_b_r <= wr_data;
      end else if (valid_r[rd_addr_b]) begin
        rd_data_b_r <= mem[rd_addr_b];
      end else begin
        rd_data_b_r <= '0;
      end
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

// ----- design/tdpu_alu.sv -----
// Execute logic: shifter, adder, logic ops and multiply, with NZCV update.
// Depends on tdpu_pkg.
module tdpu_alu (
  input  logic [15:0]    instruction,
  input  tdpu_pkg::dec_t dec,
  input  logic [31:0]    opnd_a,
  input  logic [31:0]    opnd_b,
  input  logic [3:0]     flags_in,
  output tdpu_pkg::exe_t exe
);

  // returns {carry, result}
  function automatic logic [32:0] shift_fn(input logic [1:0] kind, input logic [31:0] x,
                                           input logic [8:0] n, input logic cin);
    logic [32:0]        t;
    logic signed [32:0] ts;
    logic [63:0]        rr;
    begin
      t  = '0;
      ts = '0;
      rr = '0;
      if (n == 9'd0) begin
        shift_fn = {cin, x};
      end else begin
        case (kind)
          tdpu_pkg::SH_LSL: begin
            t = {1'b0, x} << n[4:0];
            if (n < 9'd32)       shift_fn = t;
            else if (n == 9'd32) shift_fn = {x[0], 32'd0};
            else                 shift_fn = '0;
          end
          tdpu_pkg::SH_LSR: begin
            t = {x, 1'b0} >> n[4:0];
            if (n < 9'd32)       shift_fn = {t[0], t[32:1]};
            else if (n == 9'd32) shift_fn = {x[31], 32'd0};
            else                 shift_fn = '0;
          end
          tdpu_pkg::SH_ASR: begin
            ts = $signed({x, 1'b0}) >>> n[4:0];
            if (n < 9'd32) shift_fn = {ts[0], ts[32:1]};
            else           shift_fn = {x[31], {32{x[31]}}};
          end
          default: begin
            rr = {x, x} >> n[4:0];
            shift_fn = {rr[31], rr[31:0]};
          end
        endcase
      end
    end
  endfunction

  // returns {carry, overflow, sum}
  function automatic logic [33:0] add_fn(input logic [31:0] a, input logic [31:0] b,
                                         input logic cin);
    logic [32:0] s;
    begin
      s = {1'b0, a} + {1'b0, b} + {32'd0, cin};
      add_fn = {s[32], ~(a[31] ^ b[31]) & (a[31] ^ s[31]), s[31:0]};
    end
  endfunction

  logic [31:0]       res;
  logic              c;
  logic              v;
  logic              we;
  logic [8:0]        sh_n;
  logic [31:0]       addsub_b;
  logic [31:0]       mul_lo;
  logic [7:0]        imm8;
  tdpu_pkg::alu_op_t alu_op;

  assign imm8   = instruction[7:0];
  assign alu_op = tdpu_pkg::alu_op_t'(instruction[9:6]);
  assign mul_lo = opnd_a * opnd_b;

  always_comb begin
    res      = '0;
    c        = flags_in[1];
    v        = flags_in[0];
    we       = 1'b0;
    sh_n     = {4'd0, instruction[10:6]};
    addsub_b = instruction[10] ? {29'd0, instruction[8:6]} : opnd_b;
    case (dec.kind)
      tdpu_pkg::KIND_SHIFT: begin
        // immediate zero on LSR/ASR encodes a shift by 32
        if (instruction[12:11] != tdpu_pkg::SH_LSL && instruction[10:6] == 5'd0) begin
          sh_n = 9'd32;
        end
        {c, res} = shift_fn(instruction[12:11], opnd_a, sh_n, c);
        we = 1'b1;
      end
      tdpu_pkg::KIND_ADDSUB: begin
        if (instruction[9]) {c, v, res} = add_fn(opnd_a, ~addsub_b, 1'b1);
        else                {c, v, res} = add_fn(opnd_a, addsub_b, 1'b0);
        we = 1'b1;
      end
      tdpu_pkg::KIND_IMM8: begin
        we = 1'b1;
        case (instruction[12:11])
          tdpu_pkg::IMM_MOV: res = {24'd0, imm8};
          tdpu_pkg::IMM_ADD: {c, v, res} = add_fn(opnd_a, {24'd0, imm8}, 1'b0);
          tdpu_pkg::IMM_SUB: {c, v, res} = add_fn(opnd_a, ~{24'd0, imm8}, 1'b1);
          default: begin
            {c, v, res} = add_fn(opnd_a, ~{24'd0, imm8}, 1'b1);
            we = 1'b0;
          end
        endcase
      end
      tdpu_pkg::KIND_ALU: begin
        we = 1'b1;
        case (alu_op)
          tdpu_pkg::ALU_AND: res = opnd_a & opnd_b;
          tdpu_pkg::ALU_EOR: res = opnd_a ^ opnd_b;
          tdpu_pkg::ALU_LSL: {c, res} = shift_fn(tdpu_pkg::SH_LSL, opnd_a,
                                                 {1'b0, opnd_b[7:0]}, c);
          tdpu_pkg::ALU_LSR: {c, res} = shift_fn(tdpu_pkg::SH_LSR, opnd_a,
                                                 {1'b0, opnd_b[7:0]}, c);
          tdpu_pkg::ALU_ASR: {c, res} = shift_fn(tdpu_pkg::SH_ASR, opnd_a,
                                                 {1'b0, opnd_b[7:0]}, c);
          tdpu_pkg::ALU_ADC: {c, v, res} = add_fn(opnd_a, opnd_b, c);
          tdpu_pkg::ALU_SBC: {c, v, res} = add_fn(opnd_a, ~opnd_b, c);
          tdpu_pkg::ALU_ROR: {c, res} = shift_fn(tdpu_pkg::SH_ROR, opnd_a,
                                                 {1'b0, opnd_b[7:0]}, c);
          tdpu_pkg::ALU_TST: begin
            res = opnd_a & opnd_b;
            we  = 1'b0;
          end
          tdpu_pkg::ALU_NEG: {c, v, res} = add_fn(32'd0, ~opnd_b, 1'b1);
          tdpu_pkg::ALU_CMP: begin
            {c, v, res} = add_fn(opnd_a, ~opnd_b, 1'b1);
            we = 1'b0;
          end
          tdpu_pkg::ALU_CMN: begin
            {c, v, res} = add_fn(opnd_a, opnd_b, 1'b0);
            we = 1'b0;
          end
          tdpu_pkg::ALU_ORR: res = opnd_a | opnd_b;
          tdpu_pkg::ALU_MUL: res = mul_lo;
          tdpu_pkg::ALU_BIC: res = opnd_a & ~opnd_b;
          default:           res = ~opnd_b;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (dec.kind == tdpu_pkg::KIND_UNSUP || dec.kind == tdpu_pkg::KIND_UNKNOWN) begin
      exe.status = (dec.kind == tdpu_pkg::KIND_UNSUP) ? tdpu_pkg::STATUS_UNSUP
                                                       : tdpu_pkg::STATUS_UNKNOWN;
      exe.we     = 1'b0;
      exe.rd     = '0;
      exe.value  = '0;
      exe.flags  = flags_in;
    end else begin
      exe.status = tdpu_pkg::STATUS_EXEC;
      exe.we     = we;
      exe.rd     = dec.rd;
      exe.value  = res;
      exe.flags  = {res[31], res == 32'd0, c, v};
    end
  end

endmodule

// ----- design/thumb_data_processing_unit.sv -----
// Channel   Handshake                Payload
// in        in_valid, in_stall       in_instruction
// out       out_valid, out_stall     out_status, out_write_enable, out_dest_index, ...
//
// One instruction per cycle while out_stall is low; input register, then result register.
// Operands are read from the register array as the beat is taken, with bypass from
// the instruction executing in that cycle; write-back happens as the instruction executes.
// rst_n clears all registers to zero and the flags to zero; ready straight after reset.
// out_stall holds the result register and, once the input register is full, in_stall.
// Top level of the Thumb data-processing unit; depends on tdpu_pkg, tdpu_decode,
// tdpu_regfile, tdpu_alu and the assertion macro header.
`include "thumb_data_processing_unit_macros.svh"

module thumb_data_processing_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_instruction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_write_enable,
  output logic [2:0]  out_dest_index,
  output logic [31:0] out_result_value,
  output logic [3:0]  out_flags_nzcv
);

  tdpu_pkg::dec_t dec_in;
  tdpu_pkg::dec_t dec_r;
  tdpu_pkg::exe_t exe;
  tdpu_pkg::exe_t out_r;
  logic [15:0]    instr_r;
  logic           in_valid_r;
  logic           in_valid_nxt;
  logic           out_valid_r;
  logic           out_valid_nxt;
  logic [3:0]     flags_r;
  logic [3:0]     flags_nxt;
  logic           in_take;
  logic           exec_fire;
  logic [31:0]    opnd_a;
  logic [31:0]    opnd_b;

  assign exec_fire = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && out_valid_r && out_stall;
  assign in_take   = in_valid && !in_stall;

  tdpu_decode u_decode (
    .instruction (in_instruction),
    .dec         (dec_in)
  );

  tdpu_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_take),
    .rd_addr_a (dec_in.addr_a),
    .rd_addr_b (dec_in.addr_b),
    .rd_data_a (opnd_a),
    .rd_data_b (opnd_b),
    .wr_en     (exec_fire && exe.we),
    .wr_addr   (exe.rd),
    .wr_data   (exe.value)
  );

  tdpu_alu u_alu (
    .instruction (instr_r),
    .dec         (dec_r),
    .opnd_a      (opnd_a),
    .opnd_b      (opnd_b),
    .flags_in    (flags_r),
    .exe         (exe)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take)        in_valid_nxt = 1'b1;
    else if (exec_fire) in_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (exec_fire)       out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;

    flags_nxt = exec_fire ? exe.flags : flags_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      flags_r     <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      instr_r <= in_instruction;
      dec_r   <= dec_in;
    end
    if (exec_fire) begin
      out_r <= exe;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_write_enable = out_r.we;
  assign out_dest_index   = out_r.rd;
  assign out_result_value = out_r.value;
  assign out_flags_nzcv   = out_r.flags;

  `TDPU_ASSERT_NEXT(a_flags_hold, !exec_fire, $stable(flags_r),
                    "flags moved without an execute")
  `TDPU_ASSERT_NEXT(a_out_flags, exec_fire, out_valid_r && out_flags_nzcv == flags_r,
                    "result flags differ from architectural flags")
  `TDPU_ASSERT_NOW(a_noexec_quiet, out_valid_r && out_status != tdpu_pkg::STATUS_EXEC,
                   !out_write_enable && out_result_value == 32'd0 && out_dest_index == 3'd0,
                   "unexecuted beat carries a write")

endmodule
